// File: design/fkt_pkg.sv
// ----------------------------------------------------------------------------
// Find-or-insert key table package
// Field widths, command codes, flag record and sequencer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fkt_pkg;

    // Field widths of the request and result ports.
    localparam int CMD_W   = 2;
    localparam int WORD_W  = 32;
    localparam int KEY_W   = 3 * WORD_W;
    localparam int IDX_W   = 8;
    localparam int POP_W   = 16;
    localparam int FOUND_W = 8;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REPORT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // Per-entry population flags.
    typedef struct packed {
        logic extinct;
        logic last_zero;
    } flags_t;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_REPORT = 3'b100
    } state_t;

endpackage

// File: design/find_or_insert_key_table.sv
// ----------------------------------------------------------------------------
// Find-or-insert key table
// Stores three-word keys in fill order, finds or inserts a key, and tracks
// an extinction mark per entry from population reports.
//
// Channel   Direction  Handshake          Payload
// request   in         start & !busy      command, key_word_a/b/c,
//                                         entry_index, population
// result    out        done (one cycle)   found_index, created, extinct,
//                                         table_full
//
// A lookup scans the stored entries in index order, one per cycle, through the
// single key memory read port and a shared 96-bit comparator; it ends at the
// first hit, else inserts the key unless the table is full. A report to a
// stored entry reads the flag memory, then writes it unless the entry is
// already extinct; clear, the unused command and a report to an entry not
// stored complete on acceptance. Results appear on the cycle after the last
// step of the request and cannot be stalled. Reset needs no clearing pass:
// entries at or above the fill count are never used, and an insert initializes an entry's flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module find_or_insert_key_table #(
    parameter int ENTRIES = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [fkt_pkg::CMD_W-1:0]     command,
    input  logic [fkt_pkg::WORD_W-1:0]    key_word_a,
    input  logic [fkt_pkg::WORD_W-1:0]    key_word_b,
    input  logic [fkt_pkg::WORD_W-1:0]    key_word_c,
    input  logic [fkt_pkg::IDX_W-1:0]     entry_index,
    input  logic [fkt_pkg::POP_W-1:0]     population,
    output logic                          done,
    output logic [fkt_pkg::FOUND_W-1:0]   found_index,
    output logic                          created,
    output logic                          extinct,
    output logic                          table_full
);

    import fkt_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    // Control registers.
    state_t              state_reg, state_next;
    logic [CW-1:0]       next_free_reg, next_free_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [IW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic                done_reg, done_next;

    // Payload registers.
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic                pop_zero_reg, pop_zero_next;
    logic [FOUND_W-1:0]  found_reg, found_next;
    logic                created_reg, created_next;
    logic                extinct_reg, extinct_next;
    logic                full_reg, full_next;

    // Memories and their ports.
    logic [KEY_W-1:0]    key_mem [ENTRIES];
    flags_t              flag_mem [ENTRIES];
    logic [KEY_W-1:0]    key_rd_reg;
    flags_t              flag_rd_reg;
    logic                key_we;
    logic                flag_we;
    logic [IW-1:0]       flag_wr_addr;
    flags_t              flag_wr_data;
    logic [IW-1:0]       flag_rd_addr;

    // Helper signals.
    logic                accept;
    logic                idx_ok;
    logic                hit;
    logic                report_zero;

    assign busy        = (state_reg != S_IDLE);
    assign accept      = start && !busy;
    assign idx_ok      = XW'(entry_index) < XW'(next_free_reg);
    assign hit         = cmp_vld_reg && (key_rd_reg == key_reg);
    assign report_zero = pop_zero_reg && flag_rd_reg.last_zero;
    assign flag_rd_addr = IW'(entry_index);

    // Sequencer and result selection.
    always_comb
    begin
        state_next     = state_reg;
        next_free_next = next_free_reg;
        cnt_next       = cnt_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_vld_next   = cmp_vld_reg;
        done_next      = 1'b0;
        key_next       = key_reg;
        idx_next       = idx_reg;
        pop_zero_next  = pop_zero_reg;
        found_next     = found_reg;
        created_next   = created_reg;
        extinct_next   = extinct_reg;
        full_next      = full_reg;
        key_we         = 1'b0;
        flag_we        = 1'b0;
        flag_wr_addr   = idx_reg;
        flag_wr_data   = flag_rd_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    found_next   = '0;
                    created_next = 1'b0;
                    extinct_next = 1'b0;
                    full_next    = 1'b0;
                    case (command)
                        CMD_LOOKUP:
                        begin
                            key_next     = {key_word_a, key_word_b, key_word_c};
                            cnt_next     = '0;
                            cmp_vld_next = 1'b0;
                            state_next   = S_SCAN;
                        end
                        CMD_REPORT:
                        begin
                            if (idx_ok)
                            begin
                                idx_next      = IW'(entry_index);
                                pop_zero_next = (population == '0);
                                state_next    = S_REPORT;
                            end
                            else
                            begin
                                found_next = entry_index;
                                done_next  = 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            next_free_next = '0;
                            done_next      = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    // First match in index order wins.
                    found_next = FOUND_W'(cmp_idx_reg);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (cnt_reg == next_free_reg)
                begin
                    // All stored entries compared without a match.
                    if (next_free_reg < CW'(ENTRIES))
                    begin
                        key_we                 = 1'b1;
                        flag_we                = 1'b1;
                        flag_wr_addr           = next_free_reg[IW-1:0];
                        flag_wr_data.extinct   = 1'b0;
                        flag_wr_data.last_zero = 1'b1;
                        next_free_next         = next_free_reg + 1'b1;
                        found_next             = FOUND_W'(next_free_reg[IW-1:0]);
                        created_next           = 1'b1;
                    end
                    else
                    begin
                        full_next = 1'b1;
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    // Issue the read of the next stored key.
                    cmp_idx_next = cnt_reg[IW-1:0];
                    cmp_vld_next = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                end
            end

            S_REPORT:
            begin
                found_next = FOUND_W'(idx_reg);
                if (flag_rd_reg.extinct)
                begin
                    extinct_next = 1'b1;
                end
                else
                begin
                    flag_we                = 1'b1;
                    flag_wr_data.extinct   = report_zero;
                    flag_wr_data.last_zero = pop_zero_reg;
                    extinct_next           = report_zero;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            next_free_reg <= '0;
            cnt_reg       <= '0;
            cmp_idx_reg   <= '0;
            cmp_vld_reg   <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            cnt_reg       <= cnt_next;
            cmp_idx_reg   <= cmp_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            done_reg      <= done_next;
        end
    end

    // Payload and result registers.
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        idx_reg      <= idx_next;
        pop_zero_reg <= pop_zero_next;
        found_reg    <= found_next;
        created_reg  <= created_next;
        extinct_reg  <= extinct_next;
        full_reg     <= full_next;
    end

    // Key memory: one write port at the fill index, one registered read port.
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[next_free_reg[IW-1:0]] <= key_reg;
        end
        key_rd_reg <= key_mem[cnt_reg[IW-1:0]];
    end

    // Flag memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[flag_wr_addr] <= flag_wr_data;
        end
        flag_rd_reg <= flag_mem[flag_rd_addr];
    end

    assign done        = done_reg;
    assign found_index = found_reg;
    assign created     = created_reg;
    assign extinct     = extinct_reg;
    assign table_full  = full_reg;

    // The fill count never passes the table size.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg <= CW'(ENTRIES))
        else $error("fill count beyond table size");

    // The scan pointer never runs past the fill count.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (cnt_reg <= next_free_reg))
        else $error("scan pointer beyond fill count");

    // An insert leaves at least one stored entry behind it.
    a_insert_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && created_reg) |-> (next_free_reg != '0))
        else $error("insert reported with empty table");

    // A result carries at most one of created, extinct and table full.
    a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $onehot0({created_reg, extinct_reg, full_reg}))
        else $error("conflicting result flags");

    // A result strobe always ends a request, leaving the block idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while busy");

endmodule

// File: sim/find_or_insert_key_table_tb.sv
// ----------------------------------------------------------------------------
// Find-or-insert key table testbench
// Drives lookup, report, clear and unused requests through the start/busy
// handshake and predicts every result from a shadow copy of the table, its
// extinction flags and its fill count. Each done strobe is checked field by
// field against the oldest predicted result. Stimulus is a short directed
// run followed by random episodes, two of which fill the table to capacity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module find_or_insert_key_table_tb;

    import fkt_pkg::*;

    localparam int ENTRIES     = 256;
    localparam int ITEM_TARGET = 1000;
    localparam int DRAIN_WAIT  = ENTRIES + 40;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int MAX_REPORTS = 10;

    // The block ignores this command value.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] ka;
        logic [WORD_W-1:0] kb;
        logic [WORD_W-1:0] kc;
        logic [IDX_W-1:0]  idx;
        logic [POP_W-1:0]  pop;
    } table_req_t;

    typedef struct packed {
        logic [FOUND_W-1:0] found;
        logic               created;
        logic               extinct;
        logic               full;
    } table_ans_t;

    typedef struct packed {
        table_req_t req;
        table_ans_t ans;
    } answer_rec_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [CMD_W-1:0]    command = '0;
    logic [WORD_W-1:0]   key_word_a = '0;
    logic [WORD_W-1:0]   key_word_b = '0;
    logic [WORD_W-1:0]   key_word_c = '0;
    logic [IDX_W-1:0]    entry_index = '0;
    logic [POP_W-1:0]    population = '0;
    logic                done;
    logic [FOUND_W-1:0]  found_index;
    logic                created;
    logic                extinct;
    logic                table_full;

    // Requests waiting to be sent and results waiting to arrive.
    table_req_t          request_queue [$];
    answer_rec_t         answer_queue [$];

    // Keys the generator knows to be stored, in table order.
    logic [KEY_W-1:0]    gen_pool [$];

    // Shadow copy of the table contents.
    logic [KEY_W-1:0]    shadow_key [ENTRIES];
    bit                  shadow_valid [ENTRIES];
    bit                  shadow_extinct [ENTRIES];
    bit                  shadow_last_zero [ENTRIES];
    int                  shadow_fill;

    int                  req_accepted = 0;
    int                  send_idle_pct;
    int                  fail_count = 0;
    int unsigned         cycle_count = 0;
    table_req_t          next_req;
    answer_rec_t         new_answer;
    answer_rec_t         oldest_answer;
    table_ans_t          seen_ans;

    find_or_insert_key_table #(
        .ENTRIES(ENTRIES)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .key_word_a(key_word_a),
        .key_word_b(key_word_b),
        .key_word_c(key_word_c),
        .entry_index(entry_index),
        .population(population),
        .done(done),
        .found_index(found_index),
        .created(created),
        .extinct(extinct),
        .table_full(table_full)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Empty the shadow table, as reset and the clear command do.
    function automatic void empty_shadow();
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_valid[i]     = 1'b0;
            shadow_extinct[i]   = 1'b0;
            shadow_last_zero[i] = 1'b1;
        end
        shadow_fill = 0;
    endfunction

    // Compute the result of one request and update the shadow table.
    function automatic table_ans_t predict_table_answer(table_req_t rq);
        table_ans_t a;
        logic       hit;
        logic       zero;
        a   = '0;
        hit = 1'b0;
        case (rq.cmd)
            CMD_LOOKUP:
            begin
                // The lowest matching index wins.
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!hit && shadow_valid[i] && shadow_key[i] == {rq.ka, rq.kb, rq.kc})
                    begin
                        a.found = i[FOUND_W-1:0];
                        hit     = 1'b1;
                    end
                end
                if (!hit)
                begin
                    if (shadow_fill < ENTRIES)
                    begin
                        shadow_key[shadow_fill]       = {rq.ka, rq.kb, rq.kc};
                        shadow_valid[shadow_fill]     = 1'b1;
                        shadow_extinct[shadow_fill]   = 1'b0;
                        shadow_last_zero[shadow_fill] = 1'b1;
                        a.found   = shadow_fill[FOUND_W-1:0];
                        a.created = 1'b1;
                        shadow_fill++;
                    end
                    else
                    begin
                        a.full = 1'b1;
                    end
                end
            end
            CMD_REPORT:
            begin
                a.found = rq.idx;
                if (int'(rq.idx) < ENTRIES && shadow_valid[rq.idx])
                begin
                    // An extinct entry keeps its mark and its sample bit.
                    if (!shadow_extinct[rq.idx])
                    begin
                        zero = (rq.pop == '0);
                        if (zero && shadow_last_zero[rq.idx])
                            shadow_extinct[rq.idx] = 1'b1;
                        shadow_last_zero[rq.idx] = zero;
                    end
                    a.extinct = shadow_extinct[rq.idx];
                end
            end
            CMD_CLEAR:
            begin
                empty_shadow();
            end
            default:
            begin
            end
        endcase
        return a;
    endfunction

    task automatic queue_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                 logic [IDX_W-1:0] idx, logic [POP_W-1:0] pop);
        table_req_t rq;
        rq.cmd = cmd;
        {rq.ka, rq.kb, rq.kc} = key;
        rq.idx = idx;
        rq.pop = pop;
        request_queue = {request_queue, rq};
    endtask

    function automatic logic [KEY_W-1:0] random_key96();
        return {$urandom, $urandom, $urandom};
    endfunction

    // A lookup; the generator pool follows the table so later hits are known.
    task automatic queue_lookup(logic [KEY_W-1:0] key);
        bit known;
        known = 1'b0;
        foreach (gen_pool[i])
            if (gen_pool[i] == key)
                known = 1'b1;
        if (!known && gen_pool.size() < ENTRIES)
            gen_pool = {gen_pool, key};
        queue_request(CMD_LOOKUP, key, IDX_W'($urandom_range(255)),
                      POP_W'($urandom_range(16'hFFFF)));
    endtask

    task automatic queue_report(int idx, logic [POP_W-1:0] pop);
        queue_request(CMD_REPORT, random_key96(), idx[IDX_W-1:0], pop);
    endtask

    // Clear or unused command with a random payload.
    task automatic queue_plain(logic [CMD_W-1:0] cmd);
        if (cmd == CMD_CLEAR)
            gen_pool.delete();
        queue_request(cmd, random_key96(), IDX_W'($urandom_range(255)),
                      POP_W'($urandom_range(16'hFFFF)));
    endtask

    // Random keys, some with all-zero or all-one words, or one bit away from a stored key.
    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        for (int w = 0; w < 3; w++)
        begin
            case ($urandom_range(9))
                0:       k[w*WORD_W +: WORD_W] = '0;
                1:       k[w*WORD_W +: WORD_W] = '1;
                default: k[w*WORD_W +: WORD_W] = $urandom;
            endcase
        end
        if (gen_pool.size() > 0 && $urandom_range(4) == 0)
            k = gen_pool[$urandom_range(gen_pool.size() - 1)] ^ (96'd1 << $urandom_range(95));
        return k;
    endfunction

    // Sender idling follows the number of requests already sent.
    always_comb
    begin
        case ((req_accepted / 200) % 4)
            1:       send_idle_pct = 73;
            3:       send_idle_pct = 30;
            default: send_idle_pct = 0;
        endcase
    end

    // Request driver: predicts each request as it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start       <= 1'b0;
            command     <= '0;
            key_word_a  <= '0;
            key_word_b  <= '0;
            key_word_c  <= '0;
            entry_index <= '0;
            population  <= '0;
            empty_shadow();
        end
        else
        begin
            if (start && !busy)
            begin
                next_req = '{command, key_word_a, key_word_b, key_word_c,
                             entry_index, population};
                new_answer.req = next_req;
                new_answer.ans = predict_table_answer(next_req);
                answer_queue = {answer_queue, new_answer};
                req_accepted++;
            end
            if (!start || !busy)
            begin
                if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_req = request_queue.pop_front();
                    command     <= next_req.cmd;
                    key_word_a  <= next_req.ka;
                    key_word_b  <= next_req.kb;
                    key_word_c  <= next_req.kc;
                    entry_index <= next_req.idx;
                    population  <= next_req.pop;
                    start       <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result monitor: every done strobe is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            seen_ans = '{found_index, created, extinct, table_full};
            if (answer_queue.size() == 0)
            begin
                if (fail_count < MAX_REPORTS)
                    $display("unexpected result: found_index=%0d created=%0b extinct=%0b "
                             , seen_ans.found, seen_ans.created, seen_ans.extinct,
                             "table_full=%0b", seen_ans.full);
                fail_count++;
            end
            else
            begin
                oldest_answer = answer_queue.pop_front();
                if (seen_ans != oldest_answer.ans)
                begin
                    if (fail_count < MAX_REPORTS)
                    begin
                        $display("mismatch on command %0d index %0d population %0d:",
                                 oldest_answer.req.cmd, oldest_answer.req.idx,
                                 oldest_answer.req.pop);
                        $display("  expected found_index=%0d created=%0b extinct=%0b "
                                 , oldest_answer.ans.found, oldest_answer.ans.created,
                                 oldest_answer.ans.extinct,
                                 "table_full=%0b", oldest_answer.ans.full);
                        $display("  actual   found_index=%0d created=%0b extinct=%0b "
                                 , seen_ans.found, seen_ans.created, seen_ans.extinct,
                                 "table_full=%0b", seen_ans.full);
                    end
                    fail_count++;
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("find_or_insert_key_table_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        int pick;
        int episode;

        // Directed part: key extremes, hits, extinction rules and odd commands.
        queue_lookup('0);
        queue_lookup('1);
        queue_lookup('0);
        queue_lookup({{(KEY_W-1){1'b1}}, 1'b0});
        queue_lookup('1);
        queue_report(0, 16'h0000);
        queue_report(0, 16'hFFFF);
        queue_report(1, 16'hFFFF);
        queue_report(1, 16'h0000);
        queue_report(1, 16'h0000);
        queue_report(2, 16'h0001);
        queue_report(2, 16'h0000);
        queue_report(3, 16'h0000);
        queue_report(255, 16'h0000);
        queue_request(CMD_UNUSED, '1, '1, '1);
        queue_plain(CMD_CLEAR);
        queue_report(0, 16'h0000);
        queue_lookup('1);
        queue_lookup('0);
        queue_report(1, 16'h8000);

        // Random episodes; two of them fill the table and run past full.
        episode = 0;
        while (request_queue.size() < ITEM_TARGET)
        begin
            if (episode == 2 || episode == 9)
            begin
                queue_plain(CMD_CLEAR);
                while (gen_pool.size() < ENTRIES)
                begin
                    if (gen_pool.size() > 0 && $urandom_range(9) == 0)
                        queue_lookup(gen_pool[$urandom_range(gen_pool.size() - 1)]);
                    else
                        queue_lookup(fresh_key());
                end
                repeat (3) queue_lookup(random_key96());
                queue_lookup(gen_pool[ENTRIES-1]);
                queue_report(ENTRIES - 1, 16'h0000);
                queue_report(ENTRIES - 1, 16'hFFFF);
                queue_report(ENTRIES - 2, 16'h0001);
                queue_report(ENTRIES - 2, 16'h0000);
                queue_report(ENTRIES - 2, 16'h0000);
            end
            else
            begin
                if ($urandom_range(1))
                    queue_plain(CMD_CLEAR);
                repeat (40)
                begin
                    pick = $urandom_range(99);
                    if (pick < 45)
                    begin
                        if (gen_pool.size() > 0 && $urandom_range(9) < 6)
                            queue_lookup(gen_pool[$urandom_range(gen_pool.size() - 1)]);
                        else
                            queue_lookup(fresh_key());
                    end
                    else if (pick < 92)
                    begin
                        // Mostly stored entries, sometimes any index.
                        if (gen_pool.size() > 0 && $urandom_range(9) < 8)
                            pick = $urandom_range(gen_pool.size() - 1);
                        else
                            pick = $urandom_range(255);
                        case ($urandom_range(9))
                            0, 1, 2, 3, 4: queue_report(pick, 16'h0000);
                            5:             queue_report(pick, 16'hFFFF);
                            default:       queue_report(pick,
                                                        POP_W'($urandom_range(16'hFFFF)));
                        endcase
                    end
                    else if (pick < 96)
                    begin
                        queue_plain(CMD_CLEAR);
                    end
                    else
                    begin
                        queue_plain(CMD_UNUSED);
                    end
                end
            end
            episode++;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every request to go out and every result to come back.
        while (request_queue.size() != 0 || start || answer_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (answer_queue.size() != 0)
            $display("%0d expected results never arrived", answer_queue.size());
        if (fail_count == 0 && answer_queue.size() == 0)
            $display("find_or_insert_key_table_tb OK");
        else
            $display("find_or_insert_key_table_tb NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
design/fkt_pkg.sv
design/find_or_insert_key_table.sv
sim/find_or_insert_key_table_tb.sv
